FILE: rtl/fers_pkg.sv
// Package with types and constants shared by the flash erase range sequencer.
package fers_pkg;

  localparam int unsigned PagesPerBlock = 8;
  localparam int unsigned PpbLog2 = $clog2(PagesPerBlock);
  localparam int unsigned BlkW = 32 + PpbLog2;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam logic [4:0] PageBitsRst = 5'd9;
  localparam logic [4:0] AddrShiftRst = 5'd10;
  localparam logic [15:0] PageCountRst = 16'd4096;
  localparam logic [7:0] BlockOpRst = 8'd80;
  localparam logic [7:0] PageOpRst = 8'd129;

  localparam logic KindStart = 1'b0;
  localparam logic KindReady = 1'b1;

  typedef enum logic [2:0] {
    RegPageBits  = 3'd0,
    RegAddrShift = 3'd1,
    RegPageCount = 3'd2,
    RegBlockOp   = 3'd3,
    RegPageOp    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] start_address;
    logic [31:0] erase_length;
  } in_t;

  typedef struct packed {
    logic        command_valid;
    logic [7:0]  opcode;
    logic [23:0] flash_address;
    logic [31:0] erase_bytes;
    logic        finished;
    logic        out_of_range;
  } out_t;

  typedef struct packed {
    logic [4:0]  page_bits;
    logic [4:0]  address_shift;
    logic [15:0] page_count;
    logic [7:0]  block_erase_opcode;
    logic [7:0]  page_erase_opcode;
  } cfg_t;

endpackage

FILE: rtl/fers_regs.sv
// APB configuration register file of the flash erase range sequencer.
module fers_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fers_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fers_pkg::ApbDataW-1:0]  pwdata,
  output logic [fers_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output fers_pkg::cfg_t                 cfg_o
);
  import fers_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegPageBits:  cfg_d.page_bits = pwdata[4:0];
        RegAddrShift: cfg_d.address_shift = pwdata[4:0];
        RegPageCount: cfg_d.page_count = pwdata[15:0];
        RegBlockOp:   cfg_d.block_erase_opcode = pwdata[7:0];
        RegPageOp:    cfg_d.page_erase_opcode = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegPageBits:  prdata = {27'd0, cfg_q.page_bits};
      RegAddrShift: prdata = {27'd0, cfg_q.address_shift};
      RegPageCount: prdata = {16'd0, cfg_q.page_count};
      RegBlockOp:   prdata = {24'd0, cfg_q.block_erase_opcode};
      RegPageOp:    prdata = {24'd0, cfg_q.page_erase_opcode};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_bits <= PageBitsRst;
      cfg_q.address_shift <= AddrShiftRst;
      cfg_q.page_count <= PageCountRst;
      cfg_q.block_erase_opcode <= BlockOpRst;
      cfg_q.page_erase_opcode <= PageOpRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/flash_erase_range_sequencer.sv
// Top level of the flash erase range sequencer: input register, command step and result register.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | in_data_i (fers_pkg::in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (fers_pkg::out_t)
//   apb     | input     | psel, penable, pready     | paddr, pwdata, prdata
//
// Each transfer in gives one transfer out; a new item is taken every cycle unless the output stalls.
// An item waits in the input register, then one step updates the range state and registers the result.
// The result is held in the result register until out_ready_i takes it.
// Reset clears the valid flags and the range state and loads the configuration reset values.
// A stalled output holds its result and the input register still takes one more item.
module flash_erase_range_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fers_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fers_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fers_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fers_pkg::ApbDataW-1:0]  pwdata,
  output logic [fers_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import fers_pkg::*;

  cfg_t cfg;

  logic in_valid_q;
  in_t in_q;
  logic out_valid_q;
  out_t out_q, out_d;
  logic busy_q, busy_d;
  logic [31:0] next_addr_q, next_addr_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic advance;

  logic [31:0] page;
  logic [31:0] page_size;
  logic [BlkW-1:0] block_size;
  logic in_range;
  logic blk_ok;
  logic [31:0] len;
  logic [31:0] fa_full;
  logic [31:0] left_after;

  fers_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_comb begin
    page = next_addr_q >> cfg.page_bits;
    in_range = page < {16'd0, cfg.page_count};
    page_size = 32'd1 << cfg.page_bits;
    block_size = {{PpbLog2{1'b0}}, page_size} << PpbLog2;
    blk_ok = (page[PpbLog2-1:0] == '0) &&
             ({{PpbLog2{1'b0}}, bytes_left_q} >= block_size);
    if (blk_ok) begin
      len = block_size[31:0];
    end else if (bytes_left_q < page_size) begin
      len = bytes_left_q;
    end else begin
      len = page_size;
    end
    fa_full = page << cfg.address_shift;
    left_after = bytes_left_q - len;
  end

  always_comb begin
    busy_d = busy_q;
    next_addr_d = next_addr_q;
    bytes_left_d = bytes_left_q;
    out_d = '0;
    if (in_q.kind == KindStart) begin
      next_addr_d = in_q.start_address;
      bytes_left_d = in_q.erase_length;
      busy_d = (in_q.erase_length != 32'd0);
      out_d.finished = ~busy_d;
    end else if (!busy_q) begin
      out_d.finished = 1'b1;
    end else if (!in_range) begin
      busy_d = 1'b0;
      out_d.finished = 1'b1;
      out_d.out_of_range = 1'b1;
    end else begin
      next_addr_d = next_addr_q + len;
      bytes_left_d = left_after;
      busy_d = (left_after != 32'd0);
      out_d.command_valid = 1'b1;
      out_d.opcode = blk_ok ? cfg.block_erase_opcode : cfg.page_erase_opcode;
      out_d.flash_address = fa_full[23:0];
      out_d.erase_bytes = len;
      out_d.finished = ~busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q <= 1'b0;
      next_addr_q <= '0;
      bytes_left_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        busy_q <= busy_d;
        next_addr_q <= next_addr_d;
        bytes_left_q <= bytes_left_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  a_finished_matches_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.finished == !busy_q))
    else $error("Result finished flag disagrees with the range state.");

  a_busy_fall_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (out_valid_q && out_q.finished))
    else $error("Range ended without a finished result.");

  a_no_command_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.command_valid) |->
      (out_q.opcode == 8'd0 && out_q.flash_address == 24'd0 &&
       out_q.erase_bytes == 32'd0))
    else $error("Result without a command carries command fields.");

  a_abort_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_of_range) |->
      (out_q.finished && !out_q.command_valid))
    else $error("Aborted result is not a finished non-command.");
`endif

endmodule

FILE: verif/tb_top.sv
// Testbench for the flash erase range sequencer: directed table, random sequences, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import fers_pkg::*;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  cfg_t cur_cfg;
  logic range_busy;
  logic [31:0] range_next_addr;
  logic [31:0] range_bytes_left;

  out_t expected_cmds[$];
  stim_row_t stim_rows[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  cfg_t phase_cfg[7];

  flash_erase_range_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic out_t predict_erase_step(in_t it);
    out_t r;
    logic [63:0] page;
    logic [63:0] psize;
    logic [63:0] bsize;
    logic [63:0] len;
    r = '0;
    if (it.kind == KindStart) begin
      range_next_addr = it.start_address;
      range_bytes_left = it.erase_length;
      range_busy = (it.erase_length != 0);
      r.finished = !range_busy;
      return r;
    end
    if (!range_busy) begin
      r.finished = 1'b1;
      return r;
    end
    page = 64'(range_next_addr) >> cur_cfg.page_bits;
    if (page >= 64'(cur_cfg.page_count)) begin
      range_busy = 1'b0;
      r.finished = 1'b1;
      r.out_of_range = 1'b1;
      return r;
    end
    psize = 64'd1 << cur_cfg.page_bits;
    bsize = psize * PagesPerBlock;
    if ((page % PagesPerBlock) == 0 && 64'(range_bytes_left) >= bsize) begin
      len = bsize;
      r.opcode = cur_cfg.block_erase_opcode;
    end else begin
      len = (64'(range_bytes_left) < psize) ? 64'(range_bytes_left) : psize;
      r.opcode = cur_cfg.page_erase_opcode;
    end
    range_next_addr = range_next_addr + len[31:0];
    range_bytes_left = range_bytes_left - len[31:0];
    range_busy = (range_bytes_left != 0);
    r.command_valid = 1'b1;
    r.flash_address = 24'(page << cur_cfg.address_shift);
    r.erase_bytes = len[31:0];
    r.finished = !range_busy;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      note_mismatch($sformatf("mismatch on %s: expected %h, got %h", fname, want, got));
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer out: %h", out_data_o));
      end else begin
        want = expected_cmds.pop_front();
        check_field("command_valid", 32'(want.command_valid), 32'(out_data_o.command_valid));
        check_field("opcode", 32'(want.opcode), 32'(out_data_o.opcode));
        check_field("flash_address", 32'(want.flash_address), 32'(out_data_o.flash_address));
        check_field("erase_bytes", want.erase_bytes, out_data_o.erase_bytes);
        check_field("finished", 32'(want.finished), 32'(out_data_o.finished));
        check_field("out_of_range", 32'(want.out_of_range), 32'(out_data_o.out_of_range));
      end
    end
  end

  task automatic push_request(in_t it, bit typed, out_t want);
    out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_erase_step(it);
    expected_cmds.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input reg_idx_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] unused;
    apb_access(1'b1, idx, val, unused);
    case (idx)
      RegPageBits:  cur_cfg.page_bits = val[4:0];
      RegAddrShift: cur_cfg.address_shift = val[4:0];
      RegPageCount: cur_cfg.page_count = val[15:0];
      RegBlockOp:   cur_cfg.block_erase_opcode = val[7:0];
      RegPageOp:    cur_cfg.page_erase_opcode = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] cfg_reg_value(reg_idx_e idx);
    case (idx)
      RegPageBits:  return 32'(cur_cfg.page_bits);
      RegAddrShift: return 32'(cur_cfg.address_shift);
      RegPageCount: return 32'(cur_cfg.page_count);
      RegBlockOp:   return 32'(cur_cfg.block_erase_opcode);
      RegPageOp:    return 32'(cur_cfg.page_erase_opcode);
      default:      return 32'd0;
    endcase
  endfunction

  task automatic check_config();
    reg_idx_e idx;
    logic [31:0] rdata;
    for (int i = 0; i < 5; i++) begin
      idx = reg_idx_e'(i);
      apb_access(1'b0, idx, 32'd0, rdata);
      check_field($sformatf("register %s", idx.name()), cfg_reg_value(idx), rdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_address();
    logic [63:0] psize;
    logic [63:0] span;
    logic [63:0] page;
    logic [63:0] addr;
    psize = 64'd1 << cur_cfg.page_bits;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        span = psize * 4;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        return 32'(64'hFFFF_FFFF - 64'($urandom_range(0, 32'(span))));
      end
      default: begin
        page = 64'($urandom_range(0, 32'(cur_cfg.page_count)));
        if ($urandom_range(0, 1) == 1) page = page & ~64'd7;
        addr = page << cur_cfg.page_bits;
        if ($urandom_range(0, 2) == 0) addr = addr + 64'($urandom_range(0, 32'(psize - 1)));
        return addr[31:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    logic [63:0] psize;
    logic [63:0] bsize;
    logic [63:0] len;
    psize = 64'd1 << cur_cfg.page_bits;
    bsize = psize * PagesPerBlock;
    case ($urandom_range(0, 9))
      0:       len = 64'd0;
      1, 2:    len = 64'($urandom());
      3, 4:    len = 64'($urandom_range(1, 3)) * bsize;
      default: len = 64'($urandom_range(1, 12)) * psize
                     + 64'($urandom_range(0, 32'(psize - 1)));
    endcase
    return len[31:0];
  endfunction

  task automatic run_random_phase(int n_items);
    int sent;
    int n_ready;
    bit drained;
    in_t it;
    sent = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      if (!drained && sent >= n_items / 2) begin
        drain_results();
        drained = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        it.kind = KindStart;
        it.start_address = pick_address();
        it.erase_length = pick_length();
        push_request(it, 1'b0, '0);
        sent++;
        n_ready = 0;
        while (range_busy && n_ready < 24) begin
          it.kind = KindReady;
          it.start_address = $urandom();
          it.erase_length = $urandom();
          push_request(it, 1'b0, '0);
          sent++;
          n_ready++;
        end
        repeat ($urandom_range(0, 1)) begin
          it.kind = KindReady;
          push_request(it, 1'b0, '0);
          sent++;
        end
      end else begin
        it.kind = 1'($urandom_range(0, 1));
        it.start_address = $urandom();
        it.erase_length = $urandom();
        push_request(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic add_row(logic kind, logic [31:0] addr, logic [31:0] len, bit typed,
                         logic cv, logic [7:0] op, logic [23:0] fa, logic [31:0] nb,
                         logic fin, logic oor);
    stim_row_t row;
    row.item.kind = kind;
    row.item.start_address = addr;
    row.item.erase_length = len;
    row.typed = typed;
    row.want.command_valid = cv;
    row.want.opcode = op;
    row.want.flash_address = fa;
    row.want.erase_bytes = nb;
    row.want.finished = fin;
    row.want.out_of_range = oor;
    stim_rows.push_back(row);
  endtask

  initial begin
    cur_cfg = {PageBitsRst, AddrShiftRst, PageCountRst, BlockOpRst, PageOpRst};
    range_busy = 1'b0;
    range_next_addr = '0;
    range_bytes_left = '0;

    phase_cfg[0] = cur_cfg;
    phase_cfg[1] = {5'd0, 5'd0, 16'd1, 8'h00, 8'hFF};
    phase_cfg[2] = {5'd16, 5'd16, 16'd65535, 8'hFF, 8'h00};
    phase_cfg[3] = {5'd4, 5'd3, 16'd200, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    phase_cfg[4] = {5'd31, 5'd31, 16'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    phase_cfg[5] = {5'd9, 5'd12, 16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    phase_cfg[6] = {5'd20, 5'd5, 16'd65535, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};

    add_row(KindReady, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 0);
    add_row(KindStart, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 0);
    add_row(KindStart, 32'h0, 32'd8192, 1, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 1, 8'd80, 24'h0, 32'd4096, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 1, 8'd80, 24'h2000, 32'd4096, 1, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 0);
    add_row(KindStart, 32'h0, 32'd4095, 1, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 1, 8'd129, 24'h0, 32'd512, 0, 0);
    add_row(KindStart, 32'h300, 32'd5000, 1, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    repeat (6) add_row(KindReady, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    add_row(KindStart, 32'h0, 32'd1, 1, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 1, 8'd129, 24'h0, 32'd1, 1, 0);
    add_row(KindStart, 32'h001F_FE00, 32'hFFFF_FFFF, 1, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 1, 8'd129, 24'h3F_FC00, 32'd512, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 1);
    add_row(KindStart, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 8'd0, 24'h0, 32'd0, 0, 0);
    add_row(KindReady, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 1);
    add_row(KindReady, 32'h0, 32'h0, 1, 0, 8'd0, 24'h0, 32'd0, 1, 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 59;
    foreach (stim_rows[i]) push_request(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 8;
      end
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      if (ph > 0) begin
        write_reg(RegPageBits, 32'(phase_cfg[ph].page_bits));
        write_reg(RegAddrShift, 32'(phase_cfg[ph].address_shift));
        write_reg(RegPageCount, 32'(phase_cfg[ph].page_count));
        write_reg(RegBlockOp, 32'(phase_cfg[ph].block_erase_opcode));
        write_reg(RegPageOp, 32'(phase_cfg[ph].page_erase_opcode));
      end
      check_config();
      run_random_phase(218);
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
